>>> sv/sld_pkg.sv
package sld_pkg;

    // working resolution of the cordic angle path: 2^-20 degree
    localparam int WORK_FRAC = 20;
    localparam int ZW        = 30;  // cordic angle width, signed
    localparam int XW        = 32;  // cordic x / y width, signed Q2.30
    localparam int TABLE_LEN = 24;

    // configuration register indexes
    localparam logic [7:0] REG_SENSITIVITY = 8'd0;
    localparam logic [7:0] REG_DEAD_ZONE   = 8'd1;

    localparam logic signed [XW-1:0] INV_GAIN_Q30 = XW'(652032875);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(180 * (1 << WORK_FRAC));
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * (1 << WORK_FRAC));

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 flip;
    } fold_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_STEP = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_RUN  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    // arctangent of 2^-i in 2^-20 degree
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        case (i)
            0:  r = ZW'(47185920);
            1:  r = ZW'(27855475);
            2:  r = ZW'(14718068);
            3:  r = ZW'(7471121);
            4:  r = ZW'(3750058);
            5:  r = ZW'(1876857);
            6:  r = ZW'(938658);
            7:  r = ZW'(469357);
            8:  r = ZW'(234682);
            9:  r = ZW'(117342);
            10: r = ZW'(58671);
            11: r = ZW'(29335);
            12: r = ZW'(14668);
            13: r = ZW'(7334);
            14: r = ZW'(3667);
            15: r = ZW'(1833);
            16: r = ZW'(917);
            17: r = ZW'(458);
            18: r = ZW'(229);
            19: r = ZW'(115);
            20: r = ZW'(57);
            21: r = ZW'(29);
            22: r = ZW'(14);
            23: r = ZW'(7);
            default: r = '0;
        endcase
        return r;
    endfunction

    // bring an angle into plus or minus 90 degrees, noting a half-turn move
    function automatic fold_t fold_angle(input logic signed [ZW-1:0] ang);
        fold_t                r;
        logic signed [ZW-1:0] a;
        a = ang;
        r.flip = 1'b0;
        if (a > HALF_TURN) begin
            a = a - HALF_TURN - HALF_TURN;
        end
        if (a > QUARTER_TURN) begin
            a = a - HALF_TURN;
            r.flip = 1'b1;
        end else if (a < -QUARTER_TURN) begin
            a = a + HALF_TURN;
            r.flip = 1'b1;
        end
        r.z = a;
        return r;
    endfunction

endpackage

>>> sv/sld_cell.sv
module sld_cell #(
    parameter int STAGE = 0
) (
    input  logic          aclk,
    input  sld_pkg::rot_t rot_in,
    output sld_pkg::rot_t rot_out
);
    import sld_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_entry(STAGE);

    rot_t rot_reg;
    rot_t rot_next;

    // one micro-rotation, floor shifts
    always_comb begin
        if (!rot_in.z[ZW-1]) begin
            rot_next.x = rot_in.x - (rot_in.y >>> STAGE);
            rot_next.y = rot_in.y + (rot_in.x >>> STAGE);
            rot_next.z = rot_in.z - ATAN;
        end else begin
            rot_next.x = rot_in.x + (rot_in.y >>> STAGE);
            rot_next.y = rot_in.y - (rot_in.x >>> STAGE);
            rot_next.z = rot_in.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        rot_reg <= rot_next;
    end

    assign rot_out = rot_reg;

endmodule

>>> sv/stick_look_direction.sv
// stick_look_direction: camera look direction from one stick sample per beat
//
// s_ channel: one beat carries a signed stick sample per axis; x turns yaw,
// y tilts pitch. an axis moves only when its magnitude is above dead_zone.
// m_ channel: one beat per input beat with the forward unit vector in Q1.15
// and both angles in 1/2^ANGLE_FRAC_BITS degree. yaw wraps to 0..360,
// pitch is clamped to plus or minus 89 degrees.
// cfg channel: index 0 writes sensitivity (Q8.8 degrees per full deflection),
// index 1 writes dead_zone, other indexes are dropped. always ready.
//
// an input beat passes the step-size registers, the angle accumulators,
// the row of cordic cells that yaw and pitch each pass through once and
// the product registers. one item is in flight at a time; the next beat
// is taken once the result sits in the output register.
// a stalled receiver holds the result; the block finishes the next item and
// waits with it until the output register frees up.
// reset sets yaw to 90 degrees, pitch to 0, sensitivity 256, dead_zone 15.
module stick_look_direction #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // stick_x[7:0], stick_y[15:8]
    output logic         m_tvalid,
    input  logic         m_tready,
    // dir_x[15:0], dir_y[31:16], dir_z[47:32], yaw_angle[64:48], pitch_angle[80:65]
    output logic [87:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import sld_pkg::*;

    localparam int AFB    = ANGLE_FRAC_BITS;
    localparam int NIT    = (TRIG_ITERATIONS > TABLE_LEN) ? TABLE_LEN : TRIG_ITERATIONS;
    localparam int CW     = (NIT > 1) ? $clog2(NIT) : 1;
    localparam int FULL   = 360 * (1 << AFB);
    localparam int PLIM   = 89 * (1 << AFB);
    localparam int YW     = $clog2(FULL);
    localparam int PW     = $clog2(PLIM + 1) + 1;
    localparam int DW     = 9 + AFB;
    localparam int SW     = ((YW > DW) ? YW : DW) + 2;
    localparam int SH     = WORK_FRAC - AFB;

    // configuration registers
    logic [15:0] sens_reg;
    logic [6:0]  dz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= 16'd256;
            dz_reg   <= 7'd15;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SENSITIVITY: sens_reg <= cfg_data;
                REG_DEAD_ZONE:   dz_reg   <= cfg_data[6:0];
                default:  ;
            endcase
        end
    end

    // sequencer
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg;
    logic           m_valid_reg;
    logic           out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_STEP;
            ST_STEP: state_next = ST_ACC;
            ST_ACC:  state_next = ST_RUN;
            ST_RUN:  if (cnt_reg == CW'(NIT - 1)) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == ST_RUN) ? cnt_reg + CW'(1) : '0;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // stick capture and step size
    logic signed [7:0] sx_reg, sy_reg;
    logic [DW-1:0]     dx_reg, dy_reg;
    logic [7:0]        mag_x, mag_y;
    logic [23:0]       prod_x, prod_y;

    always_comb begin
        mag_x  = sx_reg[7] ? 8'(-sx_reg) : 8'(sx_reg);
        mag_y  = sy_reg[7] ? 8'(-sy_reg) : 8'(sy_reg);
        prod_x = 24'(mag_x) * 24'(sens_reg);
        prod_y = 24'(mag_y) * 24'(sens_reg);
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sx_reg <= s_tdata[7:0];
            sy_reg <= s_tdata[15:8];
        end
        if (state_reg == ST_STEP) begin
            dx_reg <= (mag_x > {1'b0, dz_reg}) ? DW'(prod_x >> (15 - AFB)) : '0;
            dy_reg <= (mag_y > {1'b0, dz_reg}) ? DW'(prod_y >> (15 - AFB)) : '0;
        end
    end

    // angle accumulators: yaw wraps, pitch clamps
    logic [YW-1:0]        yaw_reg;
    logic signed [PW-1:0] pitch_reg;
    logic signed [SW-1:0] yaw_sum, pitch_sum, yaw_wrap, pitch_clip;

    always_comb begin
        yaw_sum   = SW'(yaw_reg) + (sx_reg[7] ? -SW'(dx_reg) : SW'(dx_reg));
        pitch_sum = SW'(pitch_reg) + (sy_reg[7] ? -SW'(dy_reg) : SW'(dy_reg));
        yaw_wrap  = yaw_sum;
        if (yaw_sum >= SW'(FULL)) begin
            yaw_wrap = yaw_sum - SW'(FULL);
        end else if (yaw_sum < 0) begin
            yaw_wrap = yaw_sum + SW'(FULL);
        end
        pitch_clip = pitch_sum;
        if (pitch_sum > SW'(PLIM)) begin
            pitch_clip = SW'(PLIM);
        end else if (pitch_sum < -SW'(PLIM)) begin
            pitch_clip = -SW'(PLIM);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= YW'(90 * (1 << AFB));
            pitch_reg <= '0;
        end else if (state_reg == ST_ACC) begin
            yaw_reg   <= YW'(yaw_wrap);
            pitch_reg <= PW'(pitch_clip);
        end
    end

    // quadrant fold ahead of the cell row, stable while the row settles
    fold_t yaw_fold, pitch_fold;
    rot_t  yaw_rot [NIT+1];
    rot_t  pitch_rot [NIT+1];

    always_comb begin
        yaw_fold   = fold_angle(ZW'({{(ZW - YW){1'b0}}, yaw_reg}) <<< SH);
        pitch_fold = fold_angle(ZW'({{(ZW - PW){pitch_reg[PW-1]}}, pitch_reg}) <<< SH);
    end

    assign yaw_rot[0]   = '{x: INV_GAIN_Q30, y: '0, z: yaw_fold.z};
    assign pitch_rot[0] = '{x: INV_GAIN_Q30, y: '0, z: pitch_fold.z};

    // row of rotation cells, one iteration each
    for (genvar i = 0; i < NIT; i++) begin : g_cell
        sld_cell #(.STAGE(i)) u_yaw_cell (
            .aclk    (aclk),
            .rot_in  (yaw_rot[i]),
            .rot_out (yaw_rot[i+1])
        );
        sld_cell #(.STAGE(i)) u_pitch_cell (
            .aclk    (aclk),
            .rot_in  (pitch_rot[i]),
            .rot_out (pitch_rot[i+1])
        );
    end

    // products and rounding
    logic signed [XW-1:0] cy, sy, cp, sp;
    logic signed [63:0]   px_reg, pz_reg;
    logic signed [XW-1:0] sp_reg;
    logic signed [63:0]   rx, rz;
    logic signed [XW-1:0] ry;
    logic signed [15:0]   dir_x, dir_y, dir_z;

    always_comb begin
        cy = yaw_fold.flip   ? -yaw_rot[NIT].x   : yaw_rot[NIT].x;
        sy = yaw_fold.flip   ? -yaw_rot[NIT].y   : yaw_rot[NIT].y;
        cp = pitch_fold.flip ? -pitch_rot[NIT].x : pitch_rot[NIT].x;
        sp = pitch_fold.flip ? -pitch_rot[NIT].y : pitch_rot[NIT].y;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            px_reg <= 64'(cy) * 64'(cp);
            pz_reg <= 64'(sy) * 64'(cp);
            sp_reg <= sp;
        end
    end

    always_comb begin
        rx = (px_reg + (64'sd1 <<< 44)) >>> 45;
        rz = (pz_reg + (64'sd1 <<< 44)) >>> 45;
        ry = (sp_reg + (XW'(1) <<< 14)) >>> 15;
        dir_x = (rx > 64'sd32767) ? 16'sh7fff : (rx < -64'sd32768) ? 16'sh8000 : 16'(rx);
        dir_z = (rz > 64'sd32767) ? 16'sh7fff : (rz < -64'sd32768) ? 16'sh8000 : 16'(rz);
        dir_y = (ry > XW'(32767)) ? 16'sh7fff : (ry < -XW'(32768)) ? 16'sh8000 : 16'(ry);
    end

    // output register
    logic [87:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {7'd0, 16'(pitch_reg), 17'(yaw_reg), dir_z, dir_y, dir_x};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
